/* hdl/awcu_pkg.sv */
// Shared types and constants for the ack window / congestion update block.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package awcu_pkg;

  localparam int unsigned DATA_W           = 32;
  localparam int unsigned DIV_W            = 32;  // step squared fits in 32 bits
  localparam int unsigned STEP_W           = 16;
  localparam int unsigned DEF_WINDOW_DEPTH = 64;
  localparam int unsigned CFG_ADDR_W       = 1;

  // input modes
  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_RESEND = 2'd1;
  localparam logic [1:0] MODE_ACK    = 2'd2;

  // result status
  localparam logic [2:0] ST_ADVANCED = 3'd0;
  localparam logic [2:0] ST_STALE    = 3'd1;
  localparam logic [2:0] ST_BOGUS    = 3'd2;
  localparam logic [2:0] ST_RECORDED = 3'd3;
  localparam logic [2:0] ST_REJECT   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_SSTHRESH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_CWND_STEP = 1'b1;

  localparam logic [DATA_W-1:0] SSTHRESH_RST  = 32'd65535;
  localparam logic [STEP_W-1:0] CWND_STEP_RST = 16'd1024;
  localparam logic [DATA_W-1:0] CWND_RST      = 32'd1024;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DATA_W-1:0] divisor;
  } awcu_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } awcu_div_rsp_t;

endpackage

`default_nettype wire

/* hdl/awcu_if.sv */
// Valid/ready stream interfaces for the input and result words.
// Depends on awcu_pkg for the field widths.
`default_nettype none

interface awcu_in_if;
  import awcu_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [15:0]       ack_low;
  logic [5:0]        entry_index;
  logic [DATA_W-1:0] now_time;

  modport source (output valid, mode, ack_low, entry_index, now_time, input ready);
  modport sink   (input valid, mode, ack_low, entry_index, now_time, output ready);
endinterface

interface awcu_out_if #(
  parameter int unsigned CNT_W = 7
);
  import awcu_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [DATA_W-1:0] window_start;
  logic [CNT_W-1:0]  window_count;
  logic [DATA_W-1:0] cwnd_out;
  logic [DATA_W-1:0] rtt_out;
  logic [DATA_W-1:0] rtt_dev_out;
  logic              rtt_sampled;

  modport source (output valid, status, window_start, window_count, cwnd_out, rtt_out,
                  rtt_dev_out, rtt_sampled, input ready);
  modport sink   (input valid, status, window_start, window_count, cwnd_out, rtt_out,
                  rtt_dev_out, rtt_sampled, output ready);
endinterface

`default_nettype wire

/* hdl/awcu_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on awcu_pkg (request/response structs, widths).
`default_nettype none

module awcu_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  awcu_pkg::awcu_div_req_t req_i,
  output awcu_pkg::awcu_div_rsp_t rsp_o
);
  import awcu_pkg::*;

  localparam int unsigned ITER_W = $clog2(DIV_W);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(DIV_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] iter_q;
  logic [DATA_W-1:0] rem_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DATA_W-1:0] dvs_q;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              ge;
  logic [DATA_W-1:0] rem_d;

  // partial remainder stays below the divisor, so 32 bits hold it
  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};
  assign rem_d   = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (busy_q) begin
      iter_q <= iter_q + 1'b1;
      if (iter_q == LAST_ITER) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

/* hdl/ack_window_congestion_update.sv */
// Sender-side ack engine: send window, congestion window and RTT smoothing.
// Depends on awcu_pkg, awcu_if (awcu_in_if, awcu_out_if) and awcu_div.
//
// Usage:
//   in_if carries one command word (mode, ack_low, entry_index, now_time); out_if
//   returns exactly one result word per command. Configuration (slow start
//   threshold, growth step) is written through cfg_we_i/cfg_addr_i/cfg_wdata_i
//   while the block is idle.
//   One command at a time: in_if.ready is high only while idle, and comes back
//   in the cycle after the result word is taken. Record, resend, stale, bogus
//   and unused-mode commands pass from S_DECODE straight to S_OUT. A valid ack
//   runs S_CWND, S_RTT and S_ADV; when the head was not resent, the RTT and
//   deviation averages are also updated (two passes through one shared
//   multiply-by-reciprocal unit). When cwnd is at or above the threshold, the
//   32-step divider computes step squared over cwnd before the RTT update.
//   Reset empties the window, sets cwnd to 1024, clears RTT state and loads the
//   register defaults. The send-time and resent memories are not cleared; only
//   entries inside the window are read. A stalled receiver holds the result word
//   and the block stays busy until out_if.ready.
`default_nettype none

module ack_window_congestion_update_core #(
  parameter int unsigned WINDOW_DEPTH = awcu_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [awcu_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [awcu_pkg::DATA_W-1:0]     cfg_wdata_i,
  awcu_in_if.sink                         in_if,
  awcu_out_if.source                      out_if
);
  import awcu_pkg::*;

  localparam int unsigned AW    = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = AW + 2;
  localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(WINDOW_DEPTH);
  localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(WINDOW_DEPTH);
  localparam logic [DATA_W-1:0] HALF_SPAN = 32'h0000_8000;
  localparam logic [DATA_W-1:0] SPAN      = 32'h0001_0000;
  // floor(m/10) = (m * 0xCCCCCCCD) >> 35 for any 32-bit m
  localparam logic [DATA_W-1:0] RECIP10   = 32'hCCCC_CCCD;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_CWND     = 4'd2;
  localparam logic [3:0] S_CWND_DIV = 4'd3;
  localparam logic [3:0] S_RTT      = 4'd4;
  localparam logic [3:0] S_RTT_DEV  = 4'd5;
  localparam logic [3:0] S_RTT_MUL  = 4'd6;
  localparam logic [3:0] S_RTT_FIX  = 4'd7;
  localparam logic [3:0] S_DEV_MUL  = 4'd8;
  localparam logic [3:0] S_DEV_FIX  = 4'd9;
  localparam logic [3:0] S_ADV      = 4'd10;
  localparam logic [3:0] S_OUT      = 4'd11;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

  // (9*old + smp)/10 = old + (smp - old)/10; returns {smp >= old, m} where the
  // multiply operand m is smp - old, or old - smp - 1 so the tenth rounds down
  function automatic logic [DATA_W:0] avg_prep(input logic [DATA_W-1:0] old_v,
                                               input logic [DATA_W-1:0] smp);
    logic [DATA_W-1:0] diff;
    diff = smp - old_v;
    return (smp >= old_v) ? {1'b1, diff} : {1'b0, ~diff};
  endfunction

  // control state
  logic [3:0]        state_q, state_d;
  logic [DATA_W-1:0] ssthresh_q;
  logic [STEP_W-1:0] step_q;
  logic [DATA_W-1:0] win_start_q, win_start_d;
  logic [CNT_W-1:0]  win_count_q, win_count_d;
  logic [AW-1:0]     head_q, head_d;
  logic [DATA_W-1:0] cwnd_q, cwnd_d;
  logic [DATA_W-1:0] rtt_q, rtt_d;
  logic [DATA_W-1:0] dev_q, dev_d;
  logic [2:0]        status_q, status_d;
  logic              sampled_q, sampled_d;

  // payload and scratch
  logic [1:0]        mode_q;
  logic [15:0]       ack_low_q;
  logic [5:0]        idx_q;
  logic [DATA_W-1:0] now_q;
  logic [CNT_W-1:0]  adv_q, adv_d;
  logic [DATA_W-1:0] sample_q, sample_d;
  logic [DATA_W-1:0] absdev_q, absdev_d;

  // shared averaging unit
  logic                avg_up_q, avg_up_d;
  logic [DATA_W-1:0]   avg_m_q, avg_m_d;
  logic [2*DATA_W-1:0] prod_d, prod_q;
  logic [DATA_W-1:0]   tenth;
  logic [2*STEP_W-1:0] step_sq;

  // window memories
  logic [DATA_W-1:0] times_mem [WINDOW_DEPTH];
  logic              marks_mem [WINDOW_DEPTH];
  logic [DATA_W-1:0] time_rd_q;
  logic              mark_rd_q;
  logic              we_time, we_mark, wmark;
  logic [AW-1:0]     waddr;

  awcu_div_req_t div_req;
  awcu_div_rsp_t div_rsp;

  logic              in_fire;
  logic [SUM_W-1:0]  tail_sum, idx_sum, head_sum;
  logic [AW-1:0]     tail_slot, idx_slot, head_next;
  logic [DATA_W-1:0] ack_pos, dist_fwd, dist_back, rel;
  logic              stale, bogus;

  assign in_fire = in_if.valid && in_if.ready;

  assign step_sq = {{STEP_W{1'b0}}, step_q} * {{STEP_W{1'b0}}, step_q};
  assign prod_d  = {{DATA_W{1'b0}}, avg_m_q} * {{DATA_W{1'b0}}, RECIP10};
  assign tenth   = {3'b000, prod_q[2*DATA_W-1:DATA_W+3]};

  // circular slot arithmetic: operands stay below twice the depth
  assign tail_sum  = SUM_W'(head_q) + SUM_W'(win_count_q);
  assign tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign idx_sum   = SUM_W'(head_q) + SUM_W'(idx_q);
  assign idx_slot  = (idx_sum >= DEPTH_S) ? AW'(idx_sum - DEPTH_S) : AW'(idx_sum);
  assign head_sum  = SUM_W'(head_q) + SUM_W'(adv_q);
  assign head_next = (head_sum >= DEPTH_S) ? AW'(head_sum - DEPTH_S) : AW'(head_sum);

  // extend the 16-bit ack around the window start
  assign ack_pos   = {win_start_q[31:16], ack_low_q};
  assign dist_fwd  = ack_pos - win_start_q;
  assign dist_back = win_start_q - ack_pos;
  always_comb begin
    if ($signed(dist_back) > $signed(HALF_SPAN)) begin
      rel = dist_fwd + SPAN;
    end else if ($signed(dist_fwd) > $signed(HALF_SPAN)) begin
      rel = dist_fwd - SPAN;
    end else begin
      rel = dist_fwd;
    end
  end
  assign stale = rel[DATA_W-1] || (rel == '0);
  assign bogus = rel > DATA_W'(win_count_q);

  always_comb begin
    state_d     = state_q;
    win_start_d = win_start_q;
    win_count_d = win_count_q;
    head_d      = head_q;
    cwnd_d      = cwnd_q;
    rtt_d       = rtt_q;
    dev_d       = dev_q;
    status_d    = status_q;
    sampled_d   = sampled_q;
    adv_d       = adv_q;
    sample_d    = sample_q;
    absdev_d    = absdev_q;
    avg_up_d    = avg_up_q;
    avg_m_d     = avg_m_q;
    we_time     = 1'b0;
    we_mark     = 1'b0;
    wmark       = 1'b0;
    waddr       = tail_slot;
    div_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d   = S_OUT;
        status_d  = ST_REJECT;
        sampled_d = 1'b0;
        unique case (mode_q)
          MODE_RECORD: begin
            if (win_count_q < DEPTH_C) begin
              we_time     = 1'b1;
              we_mark     = 1'b1;
              win_count_d = win_count_q + 1'b1;
              status_d    = ST_RECORDED;
            end
          end
          MODE_RESEND: begin
            if (DATA_W'(idx_q) < DATA_W'(win_count_q)) begin
              we_mark  = 1'b1;
              wmark    = 1'b1;
              waddr    = idx_slot;
              status_d = ST_RECORDED;
            end
          end
          MODE_ACK: begin
            if (stale) begin
              status_d = ST_STALE;
            end else if (bogus) begin
              status_d = ST_BOGUS;
            end else begin
              adv_d   = rel[CNT_W-1:0];
              state_d = S_CWND;
            end
          end
          default: ;
        endcase
      end
      S_CWND: begin
        if (cwnd_q < ssthresh_q) begin
          cwnd_d  = sat_add(cwnd_q, DATA_W'(step_q));
          state_d = S_RTT;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(step_sq);
          div_req.divisor  = (cwnd_q == '0) ? DATA_W'(1) : cwnd_q;
          state_d          = S_CWND_DIV;
        end
      end
      S_CWND_DIV: begin
        if (div_rsp.done) begin
          cwnd_d  = sat_add(cwnd_q, div_rsp.quotient[DATA_W-1:0]);
          state_d = S_RTT;
        end
      end
      S_RTT: begin
        if (mark_rd_q) begin
          state_d = S_ADV;
        end else begin
          sample_d = now_q - time_rd_q;
          state_d  = S_RTT_DEV;
        end
      end
      S_RTT_DEV: begin
        absdev_d            = (sample_q >= rtt_q) ? sample_q - rtt_q : rtt_q - sample_q;
        {avg_up_d, avg_m_d} = avg_prep(rtt_q, sample_q);
        state_d             = S_RTT_MUL;
      end
      S_RTT_MUL: state_d = S_RTT_FIX;
      S_RTT_FIX: begin
        rtt_d               = avg_up_q ? rtt_q + tenth : rtt_q + ~tenth;
        {avg_up_d, avg_m_d} = avg_prep(dev_q, absdev_q);
        state_d             = S_DEV_MUL;
      end
      S_DEV_MUL: state_d = S_DEV_FIX;
      S_DEV_FIX: begin
        dev_d     = avg_up_q ? dev_q + tenth : dev_q + ~tenth;
        sampled_d = 1'b1;
        state_d   = S_ADV;
      end
      S_ADV: begin
        head_d      = head_next;
        win_start_d = win_start_q + DATA_W'(adv_q);
        win_count_d = win_count_q - adv_q;
        status_d    = ST_ADVANCED;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_if.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ssthresh_q  <= SSTHRESH_RST;
      step_q      <= CWND_STEP_RST;
      win_start_q <= '0;
      win_count_q <= '0;
      head_q      <= '0;
      cwnd_q      <= CWND_RST;
      rtt_q       <= '0;
      dev_q       <= '0;
      status_q    <= ST_REJECT;
      sampled_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_start_q <= win_start_d;
      win_count_q <= win_count_d;
      head_q      <= head_d;
      cwnd_q      <= cwnd_d;
      rtt_q       <= rtt_d;
      dev_q       <= dev_d;
      status_q    <= status_d;
      sampled_q   <= sampled_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_SSTHRESH:  ssthresh_q <= cfg_wdata_i;
          REG_CWND_STEP: step_q     <= cfg_wdata_i[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q    <= in_if.mode;
      ack_low_q <= in_if.ack_low;
      idx_q     <= in_if.entry_index;
      now_q     <= in_if.now_time;
    end
    adv_q    <= adv_d;
    sample_q <= sample_d;
    absdev_q <= absdev_d;
    avg_up_q <= avg_up_d;
    avg_m_q  <= avg_m_d;
    prod_q   <= prod_d;
  end

  // head entry is read every cycle; head only moves at the end of an ack
  always_ff @(posedge clk_i) begin
    if (we_time) begin
      times_mem[waddr] <= now_q;
    end
    if (we_mark) begin
      marks_mem[waddr] <= wmark;
    end
    time_rd_q <= times_mem[head_q];
    mark_rd_q <= marks_mem[head_q];
  end

  awcu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_if.ready         = (state_q == S_IDLE);
  assign out_if.valid        = (state_q == S_OUT);
  assign out_if.status       = status_q;
  assign out_if.window_start = win_start_q;
  assign out_if.window_count = win_count_q;
  assign out_if.cwnd_out     = cwnd_q;
  assign out_if.rtt_out      = rtt_q;
  assign out_if.rtt_dev_out  = dev_q;
  assign out_if.rtt_sampled  = sampled_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_count_q <= DEPTH_C)
    else $error("window count above depth");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_if.ready && out_if.valid))
    else $error("input taken while a result is pending");

  a_sample_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.rtt_sampled |-> out_if.status == ST_ADVANCED)
    else $error("rtt sampled without window advance");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_CWND_DIV)
    else $error("divider finished outside a wait state");

  a_advance_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADV |=> win_count_q <= $past(win_count_q))
    else $error("ack grew the window");
`endif

endmodule

`default_nettype wire

/* tb/sv/ack_window_congestion_update_core_tb.sv */
// Testbench for ack_window_congestion_update_core: random and directed command words,
// a cycle-free predictor of window, cwnd and RTT state, and in-order result checking.
// Depends on awcu_pkg and the awcu_in_if / awcu_out_if interfaces.
`timescale 1ns / 1ps

module ack_window_congestion_update_core_tb;
  import awcu_pkg::*;

  localparam int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH;
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int          DRAIN_CYCLES = 150;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] ack_low;
    logic [5:0]  entry_index;
    logic [31:0] now_time;
  } cmd_t;

  typedef struct {
    logic [2:0]       status;
    logic [31:0]      window_start;
    logic [CNT_W-1:0] window_count;
    logic [31:0]      cwnd;
    logic [31:0]      rtt;
    logic [31:0]      rtt_dev;
    logic             sampled;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DATA_W-1:0]     cfg_wdata;

  awcu_in_if                      cmd_bus ();
  awcu_out_if #(.CNT_W(CNT_W))    res_bus ();

  ack_window_congestion_update_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_addr_i (cfg_addr),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (cmd_bus),
    .out_if     (res_bus)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // stimulus side
  cmd_t    cmd_q[$];
  result_t expected_results[$];
  int      mismatch_cnt = 0;
  int      plan_items   = 0;
  logic    cmd_taken    = 1'b0;
  logic    quiet_mode   = 1'b0;   // no idling on either side
  int      stall_reqs   = 0;
  int      stall_seen   = 0;
  int      hold_left    = 0;

  // generator's view of the window, used to aim acks and resends and to fill the window
  logic [31:0] gen_start = '0;
  int          gen_count = 0;
  logic [31:0] gen_clock = 32'd1000;

  // predicted block state
  logic [31:0] thresh_m;
  logic [15:0] step_m;
  logic [31:0] start_m;
  int          count_m;
  int          head_m;
  logic [31:0] cwnd_m;
  logic [31:0] rtt_m;
  logic [31:0] dev_m;
  logic [31:0] sent_at_m [WINDOW_DEPTH];
  logic        resent_m  [WINDOW_DEPTH];

  function automatic logic [31:0] tenth_avg(logic [31:0] old, logic [31:0] sample);
    logic [63:0] acc;
    acc = 64'(old) * 64'd9 + 64'(sample);
    return 32'(acc / 64'd10);
  endfunction

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = 65'(a) + 65'(b);
    return (sum > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Applies one accepted command to the predicted state and queues its result.
  task automatic apply_command(cmd_t c);
    result_t     r;
    logic [31:0] pos;
    logic [31:0] diff;
    int          rel;
    int          slot;
    logic [31:0] div;
    logic [63:0] sq;
    logic [31:0] sample;
    logic [31:0] dev;
    r.status  = ST_REJECT;
    r.sampled = 1'b0;
    case (c.mode)
      MODE_RECORD: begin
        if (count_m < WINDOW_DEPTH) begin
          slot = (head_m + count_m) % WINDOW_DEPTH;
          sent_at_m[slot] = c.now_time;
          resent_m[slot]  = 1'b0;
          count_m++;
          r.status = ST_RECORDED;
        end
      end
      MODE_RESEND: begin
        if (int'(c.entry_index) < count_m) begin
          resent_m[(head_m + int'(c.entry_index)) % WINDOW_DEPTH] = 1'b1;
          r.status = ST_RECORDED;
        end
      end
      MODE_ACK: begin
        // widen the 16-bit ack to the position nearest the window start
        pos  = {start_m[31:16], c.ack_low};
        diff = start_m - pos;
        if ($signed(diff) > 32'sd32768) begin
          pos = pos + 32'h1_0000;
        end else begin
          diff = pos - start_m;
          if ($signed(diff) > 32'sd32768) pos = pos - 32'h1_0000;
        end
        diff = pos - start_m;
        rel  = $signed(diff);
        if (rel <= 0) begin
          r.status = ST_STALE;
        end else if (rel > count_m) begin
          r.status = ST_BOGUS;
        end else begin
          if (cwnd_m < thresh_m) begin
            cwnd_m = add_sat(cwnd_m, 64'(step_m));
          end else begin
            div    = (cwnd_m == 0) ? 32'd1 : cwnd_m;
            sq     = 64'(step_m) * 64'(step_m);
            cwnd_m = add_sat(cwnd_m, sq / 64'(div));
          end
          if (!resent_m[head_m]) begin
            sample    = c.now_time - sent_at_m[head_m];
            dev       = (sample >= rtt_m) ? sample - rtt_m : rtt_m - sample;
            rtt_m     = tenth_avg(rtt_m, sample);
            dev_m     = tenth_avg(dev_m, dev);
            r.sampled = 1'b1;
          end
          head_m  = (head_m + rel) % WINDOW_DEPTH;
          start_m = start_m + 32'(rel);
          count_m = count_m - rel;
          r.status = ST_ADVANCED;
        end
      end
      default: ;
    endcase
    r.window_start = start_m;
    r.window_count = CNT_W'(count_m);
    r.cwnd         = cwnd_m;
    r.rtt          = rtt_m;
    r.rtt_dev      = dev_m;
    expected_results.push_back(r);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Monitor: input words go to the predictor, result words are checked in order.
  always @(posedge clk_i) begin
    result_t e;
    cmd_t    c;
    cmd_taken <= cmd_bus.valid && cmd_bus.ready;
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      c.mode        = cmd_bus.mode;
      c.ack_low     = cmd_bus.ack_low;
      c.entry_index = cmd_bus.entry_index;
      c.now_time    = cmd_bus.now_time;
      apply_command(c);
    end
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none actual status %h",
                 $time, res_bus.status);
        mismatch_cnt++;
      end else begin
        e = expected_results.pop_front();
        check_field("status", 32'(e.status), 32'(res_bus.status));
        check_field("window_start", e.window_start, res_bus.window_start);
        check_field("window_count", 32'(e.window_count), 32'(res_bus.window_count));
        check_field("cwnd_out", e.cwnd, res_bus.cwnd_out);
        check_field("rtt_out", e.rtt, res_bus.rtt_out);
        check_field("rtt_dev_out", e.rtt_dev, res_bus.rtt_dev_out);
        check_field("rtt_sampled", 32'(e.sampled), 32'(res_bus.rtt_sampled));
      end
    end
  end

  // Driver: one word at a time from cmd_q, random gaps.
  always @(negedge clk_i) begin
    cmd_t c;
    if (!cmd_bus.valid || cmd_taken) begin
      if (cmd_q.size() > 0 && (quiet_mode || $urandom_range(99) >= 35)) begin
        c = cmd_q.pop_front();
        cmd_bus.valid       <= 1'b1;
        cmd_bus.mode        <= c.mode;
        cmd_bus.ack_low     <= c.ack_low;
        cmd_bus.entry_index <= c.entry_index;
        cmd_bus.now_time    <= c.now_time;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus a long hold-off on request.
  always @(negedge clk_i) begin
    if (stall_reqs != stall_seen) begin
      stall_seen    <= stall_reqs;
      hold_left     <= 400;
      res_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= quiet_mode || ($urandom_range(99) >= 35);
    end
  end

  task automatic queue_cmd(logic [1:0] m, logic [15:0] al, logic [5:0] ix, logic [31:0] t);
    cmd_t c;
    c.mode        = m;
    c.ack_low     = al;
    c.entry_index = ix;
    c.now_time    = t;
    cmd_q.push_back(c);
    plan_items++;
  endtask

  task automatic plan_record(logic [31:0] t);
    queue_cmd(MODE_RECORD, 16'($urandom), 6'($urandom), t);
    if (gen_count < WINDOW_DEPTH) gen_count++;
  endtask

  task automatic plan_resend(int ix);
    queue_cmd(MODE_RESEND, 16'($urandom), 6'(ix), $urandom);
  endtask

  // r is the distance from the window start; only 1..count moves the window
  task automatic plan_ack(int r, logic [31:0] t);
    logic [31:0] pos;
    pos = gen_start + 32'(r);
    queue_cmd(MODE_ACK, pos[15:0], 6'($urandom), t);
    if (r >= 1 && r <= gen_count) begin
      gen_start = gen_start + 32'(r);
      gen_count = gen_count - r;
    end
  endtask

  function automatic logic [31:0] next_stamp();
    gen_clock = gen_clock + $urandom_range(0, 40);
    return ($urandom_range(99) < 5) ? $urandom : gen_clock;
  endfunction

  task automatic plan_directed();
    plan_ack(0, 32'd0);                       // empty window, zero distance
    plan_ack(1, 32'd7);                       // beyond an empty window
    plan_resend(0);                           // no entries yet
    queue_cmd(MODE_UNUSED, 16'hFFFF, 6'h3F, 32'hFFFF_FFFF);
    plan_ack(-32767, 32'd0);                  // far behind
    plan_ack(32768, 32'd0);                   // half-range ahead
    plan_record(32'hFFFF_FFF0);
    plan_record(32'h0000_0000);
    plan_record(32'hFFFF_FFFF);
    plan_resend(0);
    plan_resend(63);                          // index past the tail
    plan_resend(2);
    plan_ack(1, 32'h10);                      // head resent: no sample
    plan_ack(1, 32'h5);
    plan_ack(1, 32'h0);                       // head resent again
    plan_record(32'h0);
    plan_ack(1, 32'hFFFF_FFFF);               // largest sample
    plan_record(32'hFFFF_FFFF);
    plan_ack(1, 32'h0);                       // sample wraps through zero
    plan_record(32'd100);
    plan_record(32'd120);
    plan_record(32'd130);
    plan_ack(3, 32'd400);                     // several atoms in one ack
    plan_ack(1, 32'd500);
  endtask

  task automatic plan_random(int n);
    int target;
    int pick;
    int k;
    target = plan_items + n;
    while (plan_items < target) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        k = $urandom_range(1, 8);
        repeat (k) plan_record(next_stamp());
        repeat ($urandom_range(0, 2)) plan_resend($urandom_range(0, gen_count - 1));
        repeat ($urandom_range(1, 2)) begin
          if (gen_count > 0) plan_ack($urandom_range(1, gen_count), gen_clock + $urandom_range(0, 300));
        end
      end else if (pick < 75) begin
        // fill to the brim, overflow, then drain
        while (gen_count < WINDOW_DEPTH) plan_record(next_stamp());
        repeat ($urandom_range(1, 2)) plan_record(next_stamp());
        plan_resend(WINDOW_DEPTH - 1);
        plan_ack($urandom_range(1, gen_count), gen_clock + $urandom_range(0, 300));
        if (gen_count > 0) plan_ack(gen_count, gen_clock + $urandom_range(0, 300));
      end else begin
        case ($urandom_range(4))
          0: plan_ack(-$urandom_range(0, 32767), $urandom);
          1: plan_ack($urandom_range(gen_count + 1, 32768), $urandom);
          2: if (gen_count < WINDOW_DEPTH) plan_resend($urandom_range(gen_count, 63));
             else plan_resend($urandom_range(0, 63));
          3: queue_cmd(MODE_UNUSED, 16'($urandom), 6'($urandom), $urandom);
          default: plan_resend($urandom_range(0, 63));
        endcase
      end
    end
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [31:0] d);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    if (a == REG_SSTHRESH) thresh_m = d;
    else step_m = d[15:0];
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || cmd_bus.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_addr            = '0;
    cfg_wdata           = '0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.mode        = '0;
    cmd_bus.ack_low     = '0;
    cmd_bus.entry_index = '0;
    cmd_bus.now_time    = '0;
    res_bus.ready       = 1'b0;
    thresh_m = SSTHRESH_RST;
    step_m   = CWND_STEP_RST;
    start_m  = '0;
    count_m  = 0;
    head_m   = 0;
    cwnd_m   = CWND_RST;
    rtt_m    = '0;
    dev_m    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    plan_directed();
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_SSTHRESH, 32'd0);
          write_reg(REG_CWND_STEP, 32'd1);
        end
        2: begin
          write_reg(REG_SSTHRESH, 32'hFFFF_FFFF);
          write_reg(REG_CWND_STEP, 32'd65535);
        end
        3: begin
          write_reg(REG_SSTHRESH, 32'd0);
          write_reg(REG_CWND_STEP, 32'd65535);
        end
        4: begin
          write_reg(REG_SSTHRESH, cwnd_m + $urandom_range(0, 32'h10_0000));
          write_reg(REG_CWND_STEP, $urandom_range(1, 65535));
        end
        default: ;
      endcase
      quiet_mode = (ph == 3);
      plan_random(190);
      if (ph == 1) stall_reqs++;   // receiver holds off while words keep coming
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
